### sv/o0mx_pkg.sv
`timescale 1ns / 1ps
// Package for the order-0 PPM frequency model with exclusion.
// Shared widths, limits, mode codes, sequencer states and store control struct.
package o0mx_pkg;

  localparam int NUM_SYMBOLS_DEF = 256;

  localparam int COUNT_W = 17;
  localparam int ESC_W   = 9;
  localparam int TALLY_W = 17;
  localparam int BOUND_W = 18;
  localparam int LIMIT_W = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = 17'd131071;
  localparam logic [ESC_W-1:0]   ESC_MAX     = 9'd511;
  localparam logic [TALLY_W-1:0] TALLY_MAX   = 17'd131071;
  localparam logic [BOUND_W-1:0] BOUND_MAX   = 18'd262143;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd16383;

  localparam logic [1:0] MODE_ENCODE  = 2'd0;
  localparam logic [1:0] MODE_EXCLUDE = 2'd1;
  localparam logic [1:0] MODE_CLEAR   = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_EMIT0,
    S_EMIT1,
    S_UPDATE,
    S_HALVE
  } state_t;

  typedef struct packed {
    logic cnt_we;
    logic excl_we;
    logic excl_wdata;
  } store_ctrl_t;

endpackage

### sv/o0mx_store.sv
`timescale 1ns / 1ps
// Symbol count and exclusion memories, one write and one registered read port.
// Depends on o0mx_pkg.
module o0mx_store import o0mx_pkg::*; #(
  parameter int NUM_SYMBOLS = NUM_SYMBOLS_DEF,
  localparam int AW = $clog2(NUM_SYMBOLS)
) (
  input  logic               clk,
  input  store_ctrl_t        ctrl,
  input  logic [AW-1:0]      waddr,
  input  logic [COUNT_W-1:0] cnt_wdata,
  input  logic [AW-1:0]      raddr,
  output logic [COUNT_W-1:0] rd_cnt,
  output logic               rd_excl
);

  logic [COUNT_W-1:0] cnt_mem [NUM_SYMBOLS];
  logic               excl_mem [NUM_SYMBOLS];

  always_ff @(posedge clk) begin
    if (ctrl.cnt_we) begin
      cnt_mem[waddr] <= cnt_wdata;
    end
    if (ctrl.excl_we) begin
      excl_mem[waddr] <= ctrl.excl_wdata;
    end
    rd_cnt  <= cnt_mem[raddr];
    rd_excl <= excl_mem[raddr];
  end

endmodule

### sv/order0_model_with_exclusion_top.sv
`timescale 1ns / 1ps
// Order-0 PPM model, encoder side: sequencer, accumulators and counters.
// Depends on o0mx_pkg and o0mx_store.
// Encode: one table scan through the single read port, then the results: an
// interval for a hit, or an escape followed by an order -1 interval. A halving
// pass may follow the update. Clear-exclusions sweeps the whole table; exclude,
// ignored and mode-3 transactions need no sweep. After reset a clearing pass
// runs with busy high. Results are strobed for one cycle; no backpressure.
module order0_model_with_exclusion_top import o0mx_pkg::*; #(
  parameter int NUM_SYMBOLS = NUM_SYMBOLS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode,
  input  logic [7:0]         symbol,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LIMIT_W-1:0] count_limit,
  output logic               result_valid,
  output logic [BOUND_W-1:0] low_bound,
  output logic [BOUND_W-1:0] high_bound,
  output logic [BOUND_W-1:0] total_bound,
  output logic               is_escape,
  output logic               last
);

  localparam int AW = $clog2(NUM_SYMBOLS);
  localparam int CW = $clog2(NUM_SYMBOLS + 1);
  localparam logic [CW-1:0] IDX_END  = CW'(NUM_SYMBOLS);
  localparam logic [CW-1:0] LAST_IDX = CW'(NUM_SYMBOLS - 1);

  state_t state, state_next;

  logic [CW-1:0]      idx;
  logic               pv;
  logic [AW-1:0]      pidx;
  logic [AW-1:0]      sym;
  logic               clr_counts;
  logic [BOUND_W-1:0] acc_low;
  logic [BOUND_W-1:0] acc_total;
  logic [CW-1:0]      lo1;
  logic [CW-1:0]      tot1;
  logic [COUNT_W-1:0] cur_cnt;
  logic [ESC_W-1:0]   esc;
  logic [TALLY_W-1:0] tally;
  logic [LIMIT_W-1:0] limit;
  logic [TALLY_W-1:0] sum;

  store_ctrl_t        ctrl;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      raddr;
  logic [COUNT_W-1:0] cnt_wdata;
  logic [COUNT_W-1:0] rd_cnt;
  logic               rd_excl;

  logic               accept;
  logic               sym_ok;
  logic               issuing;
  logic               other;
  logic               active;
  logic               excl_after;
  logic               hit;
  logic [BOUND_W:0]   low_esc;
  logic [BOUND_W-1:0] low_sat;
  logic [BOUND_W+1:0] high_sum;
  logic [BOUND_W-1:0] high_sat;
  logic [BOUND_W:0]   tot_sum;
  logic [BOUND_W-1:0] tot_sat;
  logic [BOUND_W:0]   low_add;
  logic [BOUND_W:0]   total_add;
  logic [COUNT_W-1:0] new_cnt;
  logic [TALLY_W-1:0] tally_inc;
  logic [COUNT_W-1:0] half;
  logic [TALLY_W:0]   sum_add;
  logic [ESC_W-1:0]   esc_half;

  o0mx_store #(.NUM_SYMBOLS(NUM_SYMBOLS)) u_store (
    .clk       (clk),
    .ctrl      (ctrl),
    .waddr     (waddr),
    .cnt_wdata (cnt_wdata),
    .raddr     (raddr),
    .rd_cnt    (rd_cnt),
    .rd_excl   (rd_excl)
  );

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign sym_ok    = {24'd0, symbol} < 32'(NUM_SYMBOLS);
  assign issuing   = (idx != IDX_END);

  // scan datapath on registered read data
  assign other      = (pidx != sym);
  assign active     = !rd_excl && (rd_cnt != '0);
  assign excl_after = rd_excl || (other && (rd_cnt != '0));
  assign low_add    = {1'b0, acc_low} + (BOUND_W + 1)'(rd_cnt);
  assign total_add  = {1'b0, acc_total} + (BOUND_W + 1)'(rd_cnt);

  // interval of a hit
  assign hit      = (cur_cnt != '0);
  assign low_esc  = {1'b0, acc_low} + (BOUND_W + 1)'(esc);
  assign low_sat  = (low_esc > {1'b0, BOUND_MAX}) ? BOUND_MAX : low_esc[BOUND_W-1:0];
  assign high_sum = (BOUND_W + 2)'(low_sat) + (BOUND_W + 2)'(cur_cnt);
  assign high_sat = (high_sum > {2'b00, BOUND_MAX}) ? BOUND_MAX : high_sum[BOUND_W-1:0];
  assign tot_sum  = {1'b0, acc_total} + (BOUND_W + 1)'(cur_cnt);
  assign tot_sat  = (tot_sum > {1'b0, BOUND_MAX}) ? BOUND_MAX : tot_sum[BOUND_W-1:0];

  // adaptation
  always_comb begin
    if (cur_cnt == '0) begin
      new_cnt = COUNT_W'(1);
    end else if (cur_cnt == COUNT_W'(1)) begin
      new_cnt = COUNT_W'(2);
    end else if (cur_cnt < COUNT_MAX) begin
      new_cnt = cur_cnt + COUNT_W'(1);
    end else begin
      new_cnt = cur_cnt;
    end
  end

  assign tally_inc = (tally == TALLY_MAX) ? tally : tally + TALLY_W'(1);
  assign half      = rd_cnt >> 1;
  assign sum_add   = {1'b0, sum} + (TALLY_W + 1)'(half);
  assign esc_half  = (esc >> 1 == '0) ? ESC_W'(1) : esc >> 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    waddr      = pidx;
    raddr      = idx[AW-1:0];
    cnt_wdata  = '0;
    case (state)
      S_CLEAR: begin
        waddr           = idx[AW-1:0];
        ctrl.excl_we    = 1'b1;
        ctrl.excl_wdata = 1'b0;
        ctrl.cnt_we     = clr_counts;
        if (idx == LAST_IDX) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        waddr = AW'(symbol);
        if (accept) begin
          if (mode == MODE_CLEAR) begin
            state_next = S_CLEAR;
          end else if (mode == MODE_EXCLUDE && sym_ok) begin
            ctrl.excl_we    = 1'b1;
            ctrl.excl_wdata = 1'b1;
          end else if (mode == MODE_ENCODE && sym_ok) begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        ctrl.excl_we    = pv && other && active;
        ctrl.excl_wdata = 1'b1;
        if (!issuing && !pv) begin
          state_next = S_EMIT0;
        end
      end
      S_EMIT0: begin
        state_next = hit ? S_UPDATE : S_EMIT1;
      end
      S_EMIT1: begin
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        waddr       = sym;
        ctrl.cnt_we = 1'b1;
        cnt_wdata   = new_cnt;
        if ({1'b0, tally_inc} > (TALLY_W + 1)'(limit)) begin
          state_next = S_HALVE;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_HALVE: begin
        ctrl.cnt_we = pv;
        cnt_wdata   = half;
        if (!issuing && !pv) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      idx          <= '0;
      pv           <= 1'b0;
      clr_counts   <= 1'b1;
      esc          <= ESC_W'(1);
      tally        <= '0;
      limit        <= LIMIT_RESET;
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == S_EMIT0) || (state == S_EMIT1);
      if (cfg_valid && cfg_ready) begin
        limit <= count_limit;
      end
      case (state)
        S_CLEAR: begin
          idx <= idx + CW'(1);
        end
        S_IDLE: begin
          idx        <= '0;
          pv         <= 1'b0;
          clr_counts <= 1'b0;
        end
        S_SCAN, S_HALVE: begin
          if (issuing) begin
            pv  <= 1'b1;
            idx <= idx + CW'(1);
          end else begin
            pv <= 1'b0;
          end
          if (state == S_HALVE && !issuing && !pv) begin
            tally <= sum;
            esc   <= esc_half;
          end
        end
        S_UPDATE: begin
          idx   <= '0;
          pv    <= 1'b0;
          tally <= tally_inc;
          if (cur_cnt == '0) begin
            if (esc < ESC_MAX) begin
              esc <= esc + ESC_W'(1);
            end
          end else if (cur_cnt == COUNT_W'(1)) begin
            if (esc > ESC_W'(1)) begin
              esc <= esc - ESC_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pidx <= idx[AW-1:0];
    case (state)
      S_IDLE: begin
        sym       <= AW'(symbol);
        acc_low   <= '0;
        acc_total <= BOUND_W'(esc);
        lo1       <= '0;
        tot1      <= '0;
      end
      S_SCAN: begin
        if (pv) begin
          if (other && active) begin
            if (pidx < sym) begin
              acc_low <= (low_add > {1'b0, BOUND_MAX}) ? BOUND_MAX : low_add[BOUND_W-1:0];
            end
            acc_total <= (total_add > {1'b0, BOUND_MAX}) ? BOUND_MAX
                                                         : total_add[BOUND_W-1:0];
          end
          if (!other) begin
            cur_cnt <= rd_cnt;
          end
          if (!excl_after) begin
            tot1 <= tot1 + CW'(1);
            if (pidx < sym) begin
              lo1 <= lo1 + CW'(1);
            end
          end
        end
      end
      S_EMIT0: begin
        if (hit) begin
          low_bound   <= low_sat;
          high_bound  <= high_sat;
          total_bound <= tot_sat;
          is_escape   <= 1'b0;
          last        <= 1'b1;
        end else begin
          low_bound   <= '0;
          high_bound  <= BOUND_W'(esc);
          total_bound <= acc_total;
          is_escape   <= 1'b1;
          last        <= 1'b0;
        end
      end
      S_EMIT1: begin
        low_bound   <= BOUND_W'(lo1);
        high_bound  <= BOUND_W'(lo1) + BOUND_W'(1);
        total_bound <= BOUND_W'(tot1);
        is_escape   <= 1'b0;
        last        <= 1'b1;
      end
      S_UPDATE: begin
        sum <= '0;
      end
      S_HALVE: begin
        if (pv) begin
          sum <= (sum_add > {1'b0, TALLY_MAX}) ? TALLY_MAX : sum_add[TALLY_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### sv/o0mx_check.sv
`timescale 1ns / 1ps
// Port-level checker for order0_model_with_exclusion_top, with its bind.
// Depends on o0mx_pkg.
module o0mx_check import o0mx_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] mode,
  input logic       result_valid,
  input logic       is_escape,
  input logic       last
);

  a_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy)
    else $error("result strobe while idle");

  a_escape_not_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && is_escape |-> !last)
    else $error("escape interval marked last");

  a_nonlast_is_escape: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |-> is_escape)
    else $error("non-final interval that is not an escape");

  a_escape_followed: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |=> result_valid && last && !is_escape)
    else $error("escape not followed by order -1 interval");

  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && mode == MODE_CLEAR |=> busy)
    else $error("clear transaction did not start a sweep");

endmodule

bind order0_model_with_exclusion_top o0mx_check u_o0mx_check (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .mode         (mode),
  .result_valid (result_valid),
  .is_escape    (is_escape),
  .last         (last)
);
